/* sv/mofb_pkg.sv */
// Shared types and constants of the monochrome OLED frame buffer.
`default_nettype none

package mofb_pkg;

    localparam int COLUMNS     = 128;
    localparam int PAGES       = 8;
    localparam int ROWS        = PAGES * 8;
    localparam int STORE_DEPTH = COLUMNS * PAGES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CMD_BYTES   = 3;

    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_LO    = 8'h00;
    localparam logic [7:0] CMD_COL_HI    = 8'h10;
    localparam logic [7:0] LAST_COLUMN   = 8'(COLUMNS - 1);
    localparam logic [7:0] LAST_ROW      = 8'(ROWS - 1);

    typedef enum logic [1:0] {
        OP_FILL    = 2'd0,
        OP_CLEAR   = 2'd1,
        OP_REFRESH = 2'd2
    } mofb_op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_DRAIN
    } mofb_state_t;

    typedef struct packed {
        logic refresh_go;
        logic fill_load;
        logic fill_step;
        logic clr_step;
    } mofb_cmd_t;

    typedef struct packed {
        logic credit_ok;
        logic fill_empty;
        logic fill_last;
        logic clr_last;
    } mofb_status_t;

endpackage

`default_nettype wire

/* sv/mono_oled_frame_buffer.sv */
// Top level of the 128x64 monochrome OLED page frame buffer.
// Refresh tick: its word goes via the pending read register and the head register to out_valid;
//   up to one tick per cycle in idle; held back when the two-word buffer fills under out_stall.
// Fill: stalls input through the fill and drain states after it is taken, one
//   read-modify-write per page byte through the single store port; an empty one does not stall.
// Clear and reset: a zeroing sweep over the whole store, one byte per cycle, input stalled.
`default_nettype none

module mono_oled_frame_buffer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] operation,
    input  wire logic [7:0] x_start,
    input  wire logic [7:0] y_start,
    input  wire logic [7:0] x_end,
    input  wire logic [7:0] y_end,
    input  wire logic       set_pixels,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            is_data,
    output logic            frame_done
);
    import mofb_pkg::*;

    // Commands from the sequencer: start a refresh word, latch fill bounds,
    // advance the fill walker, advance the clearing sweep.
    mofb_cmd_t    cmd;
    // Status back: room in the output buffer, empty rectangle, last fill
    // byte, last clear address.
    mofb_status_t status;

    // Sequencer: owns the input handshake and decides which operation runs.
    mofb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: store, fill walker with read-modify-write stage, refresh
    // position counters and the output word buffer.
    mofb_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .x_start    (x_start),
        .y_start    (y_start),
        .x_end      (x_end),
        .y_end      (y_end),
        .set_pixels (set_pixels),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .is_data    (is_data),
        .frame_done (frame_done)
    );

endmodule

`default_nettype wire

/* sv/mofb_ctrl.sv */
// Controller state machine of the monochrome OLED frame buffer.
`default_nettype none

module mofb_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [1:0]            operation,
    input  wire mofb_pkg::mofb_status_t status,
    output mofb_pkg::mofb_cmd_t        cmd
);
    import mofb_pkg::*;

    mofb_state_t state_reg;
    mofb_state_t state_next;
    logic        accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign accept = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (operation)
                        OP_FILL:
                        begin
                            if (!status.fill_empty)
                            begin
                                state_next = ST_FILL;
                            end
                        end
                        OP_CLEAR:   state_next = ST_CLEAR;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FILL:
            begin
                if (status.fill_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:   state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall       = 1'b1;
        cmd.refresh_go = 1'b0;
        cmd.fill_load  = 1'b0;
        cmd.fill_step  = 1'b0;
        cmd.clr_step   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:   cmd.clr_step = 1'b1;
            ST_IDLE:
            begin
                in_stall       = (operation == OP_REFRESH) && !status.credit_ok;
                cmd.refresh_go = in_valid && !in_stall && (operation == OP_REFRESH);
                cmd.fill_load  = in_valid && !in_stall && (operation == OP_FILL)
                                 && !status.fill_empty;
            end
            ST_FILL:    cmd.fill_step = 1'b1;
            ST_DRAIN:   in_stall = 1'b1;
            default:    in_stall = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

/* sv/mofb_datapath.sv */
// Datapath of the monochrome OLED frame buffer: pixel store, fill walker, refresh stream.
`default_nettype none

module mofb_datapath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mofb_pkg::mofb_cmd_t   cmd,
    output mofb_pkg::mofb_status_t     status,
    input  wire logic [7:0]            x_start,
    input  wire logic [7:0]            y_start,
    input  wire logic [7:0]            x_end,
    input  wire logic [7:0]            y_end,
    input  wire logic                  set_pixels,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [7:0]                 out_byte,
    output logic                       is_data,
    output logic                       frame_done
);
    import mofb_pkg::*;

    function automatic logic [7:0] reverse_byte(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

    // pixel store
    logic [7:0]        mem [STORE_DEPTH];
    logic [7:0]        mem_q_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;

    // clearing sweep
    logic [ADDR_W-1:0] clr_addr_reg;

    // fill walker
    logic [7:0]        fx_reg;
    logic [7:0]        fx_last_reg;
    logic [2:0]        fg_reg;
    logic [2:0]        fg_first_reg;
    logic [2:0]        fg_last_reg;
    logic [2:0]        fy_lo_reg;
    logic [2:0]        fy_hi_reg;
    logic              fset_reg;
    logic [7:0]        x_clip;
    logic [7:0]        y_clip;
    logic [2:0]        mask_lo;
    logic [2:0]        mask_hi;
    logic [7:0]        fill_mask;
    logic [ADDR_W-1:0] fill_addr;

    // read-modify-write stage
    logic              wr_valid_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic [7:0]        wr_mask_reg;
    logic              wr_set_reg;

    // refresh sequencer
    logic [7:0]        rpos_reg;
    logic [2:0]        rpage_reg;
    logic [7:0]        rf_const;
    logic              rf_data;
    logic              rf_done;
    logic              last_pos;
    logic              last_page;
    logic [7:0]        col_idx;
    logic [ADDR_W-1:0] rf_addr;

    // pending read and two-word output buffer
    logic              pend_valid_reg;
    logic [7:0]        pend_const_reg;
    logic              pend_data_reg;
    logic              pend_done_reg;
    logic [7:0]        pend_byte;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_data_reg;
    logic              out_done_reg;
    logic              skid_valid_reg;
    logic [7:0]        skid_byte_reg;
    logic              skid_data_reg;
    logic              skid_done_reg;
    logic              take;
    logic [1:0]        occupancy;
    logic [1:0]        occ_after;

    // fill bounds, clipped to the panel
    assign x_clip = (x_end > LAST_COLUMN) ? LAST_COLUMN : x_end;
    assign y_clip = (y_end > LAST_ROW) ? LAST_ROW : y_end;

    assign mask_lo   = (fg_reg == fg_first_reg) ? fy_lo_reg : 3'd0;
    assign mask_hi   = (fg_reg == fg_last_reg) ? fy_hi_reg : 3'd7;
    assign fill_mask = (8'hFF >> mask_lo) & (8'hFF << (3'd7 - mask_hi));
    assign fill_addr = ADDR_W'(fx_reg) * ADDR_W'(PAGES) + ADDR_W'(PAGES - 1)
                       - ADDR_W'(fg_reg);

    assign status.fill_empty = (x_start > x_clip) || (y_start > y_clip);
    assign status.fill_last  = (fx_reg == fx_last_reg) && (fg_reg == fg_last_reg);
    assign status.clr_last   = clr_addr_reg == ADDR_W'(STORE_DEPTH - 1);

    always_ff @(posedge clk)
    begin
        if (cmd.fill_load)
        begin
            fx_reg       <= x_start;
            fx_last_reg  <= x_clip;
            fg_reg       <= y_start[5:3];
            fg_first_reg <= y_start[5:3];
            fg_last_reg  <= y_clip[5:3];
            fy_lo_reg    <= y_start[2:0];
            fy_hi_reg    <= y_clip[2:0];
            fset_reg     <= set_pixels;
        end
        else if (cmd.fill_step)
        begin
            if (fg_reg == fg_last_reg)
            begin
                fg_reg <= fg_first_reg;
                fx_reg <= fx_reg + 8'd1;
            end
            else
            begin
                fg_reg <= fg_reg + 3'd1;
            end
        end
        wr_addr_reg <= fill_addr;
        wr_mask_reg <= fill_mask;
        wr_set_reg  <= fset_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_valid_reg <= 1'b0;
            clr_addr_reg <= '0;
        end
        else
        begin
            wr_valid_reg <= cmd.fill_step;
            if (cmd.clr_step)
            begin
                clr_addr_reg <= status.clr_last ? '0 : clr_addr_reg + ADDR_W'(1);
            end
        end
    end

    // refresh stream position
    always_comb
    begin
        rf_data = 1'b0;
        if (rpos_reg == 8'd0)
        begin
            rf_const = CMD_PAGE_BASE + {5'd0, rpage_reg};
        end
        else if (rpos_reg == 8'd1)
        begin
            rf_const = CMD_COL_LO;
        end
        else if (rpos_reg == 8'd2)
        begin
            rf_const = CMD_COL_HI;
        end
        else
        begin
            rf_const = 8'h00;
            rf_data  = 1'b1;
        end
    end

    assign last_pos  = rpos_reg == 8'(CMD_BYTES + COLUMNS - 1);
    assign last_page = rpage_reg == 3'(PAGES - 1);
    assign rf_done   = last_pos && last_page;
    assign col_idx   = 8'(COLUMNS - 1 + CMD_BYTES) - rpos_reg;
    assign rf_addr   = ADDR_W'(col_idx) * ADDR_W'(PAGES) + ADDR_W'(PAGES - 1)
                       - ADDR_W'(rpage_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpos_reg  <= 8'd0;
            rpage_reg <= 3'd0;
        end
        else if (cmd.refresh_go)
        begin
            rpos_reg <= last_pos ? 8'd0 : rpos_reg + 8'd1;
            if (last_pos)
            begin
                rpage_reg <= last_page ? 3'd0 : rpage_reg + 3'd1;
            end
        end
    end

    // store: one write port, one registered read port
    assign rd_en   = cmd.fill_step || (cmd.refresh_go && rf_data);
    assign rd_addr = cmd.fill_step ? fill_addr : rf_addr;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
        if (wr_valid_reg)
        begin
            mem[wr_addr_reg] <= wr_set_reg ? (mem_q_reg | wr_mask_reg)
                                           : (mem_q_reg & ~wr_mask_reg);
        end
        else if (cmd.clr_step)
        begin
            mem[clr_addr_reg] <= 8'h00;
        end
    end

    // output buffer: pending read, head register, skid register
    assign pend_byte = pend_data_reg ? reverse_byte(mem_q_reg) : pend_const_reg;
    assign take      = out_valid_reg && !out_stall;
    assign occupancy = {1'b0, out_valid_reg} + {1'b0, skid_valid_reg}
                       + {1'b0, pend_valid_reg};
    assign occ_after = occupancy - {1'b0, take};
    assign status.credit_ok = occ_after < 2'd2;

    always_ff @(posedge clk)
    begin
        if (cmd.refresh_go)
        begin
            pend_const_reg <= rf_const;
            pend_data_reg  <= rf_data;
            pend_done_reg  <= rf_done;
        end
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_byte_reg <= skid_byte_reg;
                out_data_reg <= skid_data_reg;
                out_done_reg <= skid_done_reg;
            end
            else
            begin
                out_byte_reg <= pend_byte;
                out_data_reg <= pend_data_reg;
                out_done_reg <= pend_done_reg;
            end
        end
        if (pend_valid_reg)
        begin
            skid_byte_reg <= pend_byte;
            skid_data_reg <= pend_data_reg;
            skid_done_reg <= pend_done_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= cmd.refresh_go;
            if (!out_valid_reg || take)
            begin
                out_valid_reg  <= skid_valid_reg || pend_valid_reg;
                skid_valid_reg <= skid_valid_reg && pend_valid_reg;
            end
            else if (pend_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign is_data    = out_data_reg;
    assign frame_done = out_done_reg;

    a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with empty head register");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pend_valid_reg && skid_valid_reg && out_valid_reg && out_stall))
        else $error("output buffer overflow");

    a_fill_write_alone: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid_reg |-> !cmd.refresh_go && !cmd.clr_step)
        else $error("fill write collides with refresh read or clear");

endmodule

`default_nettype wire

/* dv/panel_stream_checker.sv */
// Checker that mirrors the frame buffer and compares every panel word it sends.
`timescale 1ns / 100ps

module panel_stream_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic [1:0] operation,
    input  wire logic [7:0] x_start,
    input  wire logic [7:0] y_start,
    input  wire logic [7:0] x_end,
    input  wire logic [7:0] y_end,
    input  wire logic       set_pixels,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [7:0] out_byte,
    input  wire logic       is_data,
    input  wire logic       frame_done,
    output int              fail_count,
    output int              words_pending,
    output int              frames_seen
);

    import mofb_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       data;
        logic       last;
    } panel_word_t;

    logic [7:0]  pix_mem [STORE_DEPTH];
    int          scan_page;
    int          scan_pos;
    panel_word_t expected_words [$];

    // Clip the far corner to the panel; an off-panel start leaves the loop empty.
    task automatic paint_rect(input int xa, input int ya, input int xb, input int yb,
                              input logic lit);
        int         xe;
        int         ye;
        int         x;
        int         y;
        int         idx;
        logic [7:0] mask;
        xe = (xb > COLUMNS - 1) ? COLUMNS - 1 : xb;
        ye = (yb > ROWS - 1) ? ROWS - 1 : yb;
        for (x = xa; x <= xe; x++)
        begin
            for (y = ya; y <= ye; y++)
            begin
                idx  = x * PAGES + (PAGES - 1 - y / 8);
                mask = 8'h80 >> (y % 8);
                if (lit)
                    pix_mem[idx] = pix_mem[idx] | mask;
                else
                    pix_mem[idx] = pix_mem[idx] & ~mask;
            end
        end
    endtask

    // Next byte of the panel stream, read from the rotated, bit-reversed store.
    task automatic emit_panel_word(output panel_word_t w);
        int         col;
        int         idx;
        int         b;
        logic [7:0] src;
        w = '0;
        if (scan_pos == 0)
            w.value = CMD_PAGE_BASE + 8'(scan_page);
        else if (scan_pos == 1)
            w.value = CMD_COL_LO;
        else if (scan_pos == 2)
            w.value = CMD_COL_HI;
        else
        begin
            col = COLUMNS - 1 - (scan_pos - CMD_BYTES);
            idx = col * PAGES + (PAGES - 1 - scan_page);
            src = pix_mem[idx];
            for (b = 0; b < 8; b++)
                w.value[b] = src[7 - b];
            w.data = 1'b1;
        end
        scan_pos++;
        if (scan_pos == CMD_BYTES + COLUMNS)
        begin
            scan_pos = 0;
            scan_page++;
            if (scan_page == PAGES)
            begin
                scan_page = 0;
                w.last    = 1'b1;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        panel_word_t want;
        panel_word_t made;
        if (!rst_n)
        begin
            foreach (pix_mem[k])
                pix_mem[k] = '0;
            scan_page = 0;
            scan_pos  = 0;
            expected_words.delete();
            fail_count    = 0;
            words_pending = 0;
            frames_seen   = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected panel word: byte %h data %b done %b",
                                 $realtime, out_byte, is_data, frame_done);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (want.last)
                        frames_seen++;
                    if (out_byte !== want.value || is_data !== want.data ||
                        frame_done !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: panel word mismatch: expected %h/%b/%b, got %h/%b/%b",
                                     $realtime, want.value, want.data, want.last,
                                     out_byte, is_data, frame_done);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                case (mofb_op_t'(operation))
                    OP_FILL:
                        paint_rect(int'(x_start), int'(y_start), int'(x_end), int'(y_end),
                                   set_pixels);
                    OP_CLEAR:
                        foreach (pix_mem[k])
                            pix_mem[k] = '0;
                    OP_REFRESH:
                    begin
                        emit_panel_word(made);
                        expected_words.push_back(made);
                    end
                    default:
                        ;
                endcase
            end
            words_pending = expected_words.size();
        end
    end

endmodule

/* dv/testbench.sv */
// Testbench top for the OLED frame buffer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;

    import mofb_pkg::*;

    // Operation code that the block must ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 1490;
    localparam int CALM_ITEMS   = 150;   // tail of the run with no idling at all
    localparam int HOLD_BURST   = 40;    // ticks offered while the receiver holds off
    localparam int HOLD_CYCLES  = 90;    // length of the long receiver hold-off
    localparam int DRAIN_CYCLES = 16;    // settle time after the last word came out
    localparam int CYCLE_LIMIT  = 800000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] operation;
    logic [7:0] x_start;
    logic [7:0] y_start;
    logic [7:0] x_end;
    logic [7:0] y_end;
    logic       set_pixels;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       is_data;
    logic       frame_done;

    int fail_count;
    int words_pending;
    int frames_seen;

    int cycle_count = 0;
    int fills_sent  = 0;
    int clears_sent = 0;
    int ticks_sent  = 0;
    int unused_sent = 0;
    int gap_pct     = 20;

    // Shared flags: the sender owns both, the receiver only reads them.
    logic calm     = 1'b0;
    logic hold_req = 1'b0;

    always #6 clk = ~clk;

    mono_oled_frame_buffer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .x_start    (x_start),
        .y_start    (y_start),
        .x_end      (x_end),
        .y_end      (y_end),
        .set_pixels (set_pixels),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .is_data    (is_data),
        .frame_done (frame_done)
    );

    panel_stream_checker stream_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .x_start       (x_start),
        .y_start       (y_start),
        .x_end         (x_end),
        .y_end         (y_end),
        .set_pixels    (set_pixels),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .is_data       (is_data),
        .frame_done    (frame_done),
        .fail_count    (fail_count),
        .words_pending (words_pending),
        .frames_seen   (frames_seen)
    );

    // Guard against a hung block: end the run once the cycle budget is spent.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[mono_oled_frame_buffer] ERROR");
            $finish;
        end
    end

    // Present one input word at the falling edge and hold it until the block takes it.
    // Valid stays high across back-to-back words, so it is assigned once per step.
    task automatic offer_word(input logic [1:0] op, input logic [7:0] xa, input logic [7:0] ya,
                              input logic [7:0] xb, input logic [7:0] yb, input logic lit);
        @(negedge clk);
        in_valid   <= 1'b1;
        operation  <= op;
        x_start    <= xa;
        y_start    <= ya;
        x_end      <= xb;
        y_end      <= yb;
        set_pixels <= lit;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        case (op)
            OP_FILL:    fills_sent++;
            OP_CLEAR:   clears_sent++;
            OP_REFRESH: ticks_sent++;
            default:    unused_sent++;
        endcase
    endtask

    // With chance gap_pct, drop valid for a random burst, unless the tail of the run is calm.
    task automatic sender_gap();
        int n;
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            n = $urandom_range(1, 11);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1)
                @(negedge clk);
        end
    endtask

    // Refresh tick: every unused field carries random bits.
    task automatic offer_tick();
        offer_word(OP_REFRESH, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   1'($urandom));
    endtask

    // Fill with a shape picked at random. Most are small so the fill stall stays short;
    // a few cover points, wild coordinates, empty boxes, edge-to-255 boxes and near-full panels.
    task automatic offer_random_fill();
        int         shape;
        logic [7:0] xa;
        logic [7:0] ya;
        logic [7:0] xb;
        logic [7:0] yb;
        shape = $urandom_range(0, 99);
        xa = 8'($urandom_range(0, 127));
        ya = 8'($urandom_range(0, 63));
        xb = xa + 8'($urandom_range(0, 7));
        yb = ya + 8'($urandom_range(0, 15));
        if (shape >= 55 && shape < 65)
        begin
            xb = xa;
            yb = ya;
        end
        else if (shape >= 65 && shape < 75)
        begin
            xa = 8'($urandom);
            ya = 8'($urandom);
            xb = 8'($urandom);
            yb = 8'($urandom);
        end
        else if (shape >= 75 && shape < 85)
        begin
            // Make one axis run backwards so nothing gets drawn.
            if ($urandom_range(0, 1) == 0)
            begin
                xa = 8'($urandom_range(1, 255));
                xb = 8'($urandom_range(0, xa - 1));
            end
            else
            begin
                ya = 8'($urandom_range(1, 255));
                yb = 8'($urandom_range(0, ya - 1));
            end
        end
        else if (shape >= 85 && shape < 92)
        begin
            xa = 8'($urandom_range(96, 127));
            ya = 8'($urandom_range(32, 63));
            xb = 8'hFF;
            yb = 8'hFF;
        end
        else if (shape >= 92)
        begin
            xa = 8'($urandom_range(0, 15));
            ya = 8'($urandom_range(0, 15));
            xb = 8'($urandom_range(112, 127));
            yb = 8'($urandom_range(48, 63));
        end
        offer_word(OP_FILL, xa, ya, xb, yb, 1'($urandom_range(0, 99) < 70));
    endtask

    // Stop offering and wait until every predicted panel word has come out.
    task automatic await_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (words_pending != 0)
            @(negedge clk);
    endtask

    // Receiver: random stall bursts, one long hold-off on request, none in the calm tail.
    initial
    begin
        int   n;
        int   stall_pct;
        logic hold_served;
        out_stall   = 1'b0;
        stall_pct   = 10;
        hold_served = 1'b0;
        forever
        begin
            @(negedge clk);
            if (cycle_count % 256 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 8;
                    default: stall_pct = 30;
                endcase
            end
            if (hold_req && !hold_served)
            begin
                // Hold off long enough that the output buffer fills and the input stalls.
                hold_served = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < stall_pct)
            begin
                n = $urandom_range(1, 11);
                out_stall <= 1'b1;
                repeat (n)
                    @(negedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Sender: reset, directed words, then the random run and the verdict.
    initial
    begin
        int i;
        int kind;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        operation  = OP_FILL;
        x_start    = '0;
        y_start    = '0;
        x_end      = '0;
        y_end      = '0;
        set_pixels = 1'b0;
        repeat (10)
            @(negedge clk);
        rst_n = 1'b1;

        // Walk the three command bytes and the first data byte with all fields high.
        repeat (4)
            offer_word(OP_REFRESH, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        // Light both corner pixels as single points.
        offer_word(OP_FILL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        offer_word(OP_FILL, LAST_COLUMN, LAST_ROW, LAST_COLUMN, LAST_ROW, 1'b1);
        // Box that runs off the panel to 255 on both axes: clip it, do not wrap.
        offer_word(OP_FILL, 8'd120, 8'd56, 8'hFF, 8'hFF, 1'b1);
        // Box lying wholly off the panel: drop it.
        offer_word(OP_FILL, 8'd200, 8'd100, 8'hFF, 8'hFF, 1'b1);
        // Empty boxes, one backwards on each axis.
        offer_word(OP_FILL, 8'd10, 8'd5, 8'd9, 8'd20, 1'b1);
        offer_word(OP_FILL, 8'd10, 8'd20, 8'd30, 8'd19, 1'b1);
        // Whole panel lit, then an inner box cleared.
        offer_word(OP_FILL, 8'd0, 8'd0, LAST_COLUMN, LAST_ROW, 1'b1);
        offer_word(OP_FILL, 8'd4, 8'd4, 8'd123, 8'd59, 1'b0);
        // Unused operation with busy fields: ignore it.
        offer_word(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        repeat (3)
            offer_word(OP_REFRESH, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        offer_word(OP_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        offer_word(OP_REFRESH, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        // One full column across all pages.
        offer_word(OP_FILL, 8'd0, 8'd0, 8'd0, LAST_ROW, 1'b1);
        repeat (2)
            offer_word(OP_REFRESH, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 100 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 10;
                    default: gap_pct = 35;
                endcase
            end
            calm = (i >= RANDOM_ITEMS - CALM_ITEMS);
            if (i == RANDOM_ITEMS / 4)
            begin
                // Keep offering ticks back to back while the receiver holds off.
                hold_req = 1'b1;
                repeat (HOLD_BURST)
                    offer_tick();
            end
            if (i == RANDOM_ITEMS / 2)
                await_results();
            kind = $urandom_range(0, 99);
            if (kind < 80)
                offer_tick();
            else if (kind < 96)
                offer_random_fill();
            else if (kind < 98)
                offer_word(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                           1'($urandom));
            else
                offer_word(OP_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                           1'($urandom));
            sender_gap();
        end

        await_results();
        repeat (DRAIN_CYCLES)
            @(negedge clk);

        $display("Sent %0d fills, %0d clears, %0d refresh ticks and %0d ignored words.",
                 fills_sent, clears_sent, ticks_sent, unused_sent);
        $display("Checked %0d complete panel frames under idle and stall bursts on both sides.",
                 frames_seen);
        if (fail_count == 0 && words_pending == 0)
            $display("[mono_oled_frame_buffer] OK");
        else
            $display("[mono_oled_frame_buffer] ERROR");
        $finish;
    end

endmodule
